// ===== hdl/itp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itp_pkg
// Types, character codes and helper functions shared by the infix-to-postfix
// converter: payload structs, controller states, command and status bundles.
// ----------------------------------------------------------------------------
package itp_pkg;

	localparam int STACK_DEPTH_DEF = 32;

	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_NUL    = 8'h00;

	typedef logic [1:0] rank_t;

	localparam rank_t RANK_NONE = 2'd0;
	localparam rank_t RANK_ADD  = 2'd1;
	localparam rank_t RANK_MUL  = 2'd2;
	localparam rank_t RANK_POW  = 2'd3;

	typedef struct packed {
		logic [7:0] char_in;
		logic       expr_end;
	} itp_in_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       has_char;
		logic       run_last;
		logic       overflow;
	} itp_out_t;

	typedef enum logic [1:0] {
		CLS_OPERAND,
		CLS_LPAREN,
		CLS_RPAREN,
		CLS_OPER
	} cls_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_CLOSE,
		S_OPER,
		S_FETCH,
		S_FLUSH,
		S_TAIL
	} state_t;

	typedef struct packed {
		logic load;
		logic emit;
		logic emit_top;
		logic pop;
		logic push;
		logic fetch;
		logic tail;
	} itp_cmd_t;

	typedef struct packed {
		cls_t cls;
		logic last;
		logic count_zero;
		logic top_lparen;
		logic top_ge;
		logic emit_ok;
		logic out_free;
		logic pend_v;
	} itp_sts_t;

	function automatic rank_t rank_of(input logic [7:0] c);
		rank_t r;
		if (c == CH_CARET) begin
			r = RANK_POW;
		end else if (c == CH_STAR || c == CH_SLASH) begin
			r = RANK_MUL;
		end else if (c == CH_PLUS || c == CH_MINUS) begin
			r = RANK_ADD;
		end else begin
			r = RANK_NONE;
		end
		return r;
	endfunction

	function automatic cls_t classify(input logic [7:0] c);
		cls_t k;
		if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h30 && c <= 8'h39)) begin
			k = CLS_OPERAND;
		end else if (c == CH_LPAREN) begin
			k = CLS_LPAREN;
		end else if (c == CH_RPAREN) begin
			k = CLS_RPAREN;
		end else begin
			k = CLS_OPER;
		end
		return k;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/infix_to_postfix_converter_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top
// Shunting-yard converter: one infix character in per item, postfix
// characters out as result items.
//
// Input channel req_*: one character and an end-of-expression flag per item.
// Output channel rsp_*: one postfix character per item, or an end marker
// (has_char low) when the final input produced nothing; run_last marks the
// last result of an expression, overflow is the sticky full-stack flag.
// Items are taken one at a time: req_stall is low only while the controller
// is idle. Each pop, of an entry sent to the output or of a dropped '(',
// is followed by a refill of the top entry, because the stack memory read is
// registered and the new top is reloaded the cycle after each pop.
// One result is held back until the next is known, so the last result of an
// item reaches the output register as the item ends.
// Reset empties the stack, clears the overflow flag and drops any result.
// While rsp_stall is high the output register holds; once the held slot is
// also full, popping pauses and the input side stays stalled.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top
	import itp_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	output logic         req_stall,
	input  wire itp_in_t req_item,
	output logic         rsp_valid,
	input  wire logic    rsp_stall,
	output itp_out_t     rsp_item
);

	itp_cmd_t cmd;
	itp_sts_t sts;
	logic     idle;

	itp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req_valid),
		.sts      (sts),
		.cmd      (cmd),
		.idle     (idle)
	);

	itp_dpath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (req_item),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (rsp_valid),
		.out_stall (rsp_stall),
		.out_item  (rsp_item)
	);

	assign req_stall = !idle;

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !sts.count_zero)
		else $error("pop from empty stack");

	a_push_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && cmd.pop))
		else $error("push and pop in the same cycle");

	a_accept_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !sts.pend_v)
		else $error("item accepted while a result is still held");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_item.overflow) |=> (!rsp_valid || rsp_item.overflow))
		else $error("overflow flag dropped on a later result");

endmodule
`default_nettype wire

// ===== hdl/itp_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itp_ctrl
// Controller state machine: sequences evaluation, pops, pushes, top-of-stack
// refills and the end-of-item handoff of the held result.
// ----------------------------------------------------------------------------
module itp_ctrl
	import itp_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire itp_sts_t sts,
	output itp_cmd_t      cmd,
	output logic          idle
);

	state_t state_q, state_d;
	state_t ret_q, ret_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		cmd     = '0;
		idle    = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EVAL;
				end
			end
			S_EVAL: begin
				unique case (sts.cls)
					CLS_OPERAND: begin
						if (sts.emit_ok) begin
							cmd.emit = 1'b1;
							state_d  = S_FLUSH;
						end
					end
					CLS_LPAREN: begin
						cmd.push = 1'b1;
						state_d  = S_FLUSH;
					end
					CLS_RPAREN: state_d = S_CLOSE;
					CLS_OPER:   state_d = S_OPER;
					default:    state_d = S_OPER;
				endcase
			end
			S_CLOSE: begin
				priority if (sts.count_zero) begin
					state_d = S_FLUSH;
				end else if (sts.top_lparen) begin
					cmd.pop = 1'b1;
					ret_d   = S_FLUSH;
					state_d = S_FETCH;
				end else if (sts.emit_ok) begin
					cmd.emit     = 1'b1;
					cmd.emit_top = 1'b1;
					cmd.pop      = 1'b1;
					ret_d        = S_CLOSE;
					state_d      = S_FETCH;
				end
			end
			S_OPER: begin
				if (!sts.count_zero && sts.top_ge) begin
					if (sts.emit_ok) begin
						cmd.emit     = 1'b1;
						cmd.emit_top = 1'b1;
						cmd.pop      = 1'b1;
						ret_d        = S_OPER;
						state_d      = S_FETCH;
					end
				end else begin
					cmd.push = 1'b1;
					state_d  = S_FLUSH;
				end
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = ret_q;
			end
			S_FLUSH: begin
				if (sts.last && !sts.count_zero) begin
					if (sts.emit_ok) begin
						cmd.emit     = 1'b1;
						cmd.emit_top = 1'b1;
						cmd.pop      = 1'b1;
						ret_d        = S_FLUSH;
						state_d      = S_FETCH;
					end
				end else begin
					state_d = S_TAIL;
				end
			end
			S_TAIL: begin
				if (!(sts.pend_v || sts.last) || sts.out_free) begin
					cmd.tail = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ===== hdl/itp_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itp_dpath
// Datapath: operator stack memory with a registered top entry, stack count,
// sticky overflow flag, one-deep held result and the output register.
// ----------------------------------------------------------------------------
module itp_dpath
	import itp_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire itp_in_t  in_item,
	input  wire itp_cmd_t cmd,
	output itp_sts_t      sts,
	output logic          out_valid,
	input  wire logic     out_stall,
	output itp_out_t      out_item
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [7:0]    mem [STACK_DEPTH];
	logic [7:0]    rd_q;
	logic [7:0]    char_q;
	logic          last_q;
	logic [7:0]    top_q;
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [7:0]    pend_char_q;
	logic          pend_ovf_q;
	logic          pend_v_q;
	itp_out_t      out_q;
	logic          out_v_q;

	logic          count_full;
	logic          do_write;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [7:0]    emit_char;
	logic          out_free;
	logic          load_out;
	itp_out_t      out_d;

	assign count_full = (count_q == CW'(STACK_DEPTH));
	assign do_write   = cmd.push && !count_full;
	assign wr_addr    = count_q[AW-1:0];
	assign rd_addr    = AW'(count_q - CW'(2));
	assign emit_char  = cmd.emit_top ? top_q : char_q;
	assign out_free   = !out_v_q || !out_stall;
	assign load_out   = (cmd.emit && pend_v_q) || (cmd.tail && (pend_v_q || last_q));

	always_comb begin
		if (cmd.tail && !pend_v_q) begin
			out_d = '{char_out: CH_NUL, has_char: 1'b0, run_last: 1'b1,
				overflow: ovf_q};
		end else begin
			out_d = '{char_out: pend_char_q, has_char: 1'b1,
				run_last: cmd.tail && last_q, overflow: pend_ovf_q};
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[wr_addr] <= char_q;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			char_q <= in_item.char_in;
			last_q <= in_item.expr_end;
		end
		if (do_write) begin
			top_q <= char_q;
		end else if (cmd.fetch) begin
			top_q <= rd_q;
		end
		if (cmd.emit) begin
			pend_char_q <= emit_char;
			pend_ovf_q  <= ovf_q;
		end
		if (load_out) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ovf_q    <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (do_write) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.push && count_full) begin
				ovf_q <= 1'b1;
			end
			if (cmd.emit) begin
				pend_v_q <= 1'b1;
			end else if (cmd.tail) begin
				pend_v_q <= 1'b0;
			end
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.cls        = classify(char_q);
		sts.last       = last_q;
		sts.count_zero = (count_q == '0);
		sts.top_lparen = (top_q == CH_LPAREN);
		sts.top_ge     = (rank_of(top_q) >= rank_of(char_q));
		sts.emit_ok    = !pend_v_q || out_free;
		sts.out_free   = out_free;
		sts.pend_v     = pend_v_q;
	end

	assign out_valid = out_v_q;
	assign out_item  = out_q;

endmodule
`default_nettype wire
